// ----- rtl/dss_pkg.sv -----
// Shared types, codes and constants of the download segment scheduler.
package dss_pkg;

    // Default configuration of the segment table
    localparam int DEF_MAX_SEGMENTS = 16;
    localparam int DEF_OFFSET_BITS  = 48;

    // Port field widths
    localparam int OP_W    = 3;
    localparam int SLOT_W  = 4;
    localparam int BYTES_W = 48;
    localparam int STAT_W  = 3;
    localparam int WC_W    = 5;
    localparam int CFG_W   = 48;
    localparam int CFGI_W  = 1;

    // Configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_TASK_SIZE    = 1'd0;
    localparam logic [CFGI_W-1:0] CFG_WORKER_COUNT = 1'd1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SPLIT    = 3'd0;
    localparam logic [OP_W-1:0] OP_PROGRESS = 3'd1;
    localparam logic [OP_W-1:0] OP_STATUS   = 3'd2;
    localparam logic [OP_W-1:0] OP_REASSIGN = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY    = 3'd4;

    // Segment status codes
    localparam logic [STAT_W-1:0] ST_READY   = 3'd0;
    localparam logic [STAT_W-1:0] ST_RUNNING = 3'd1;
    localparam logic [STAT_W-1:0] ST_STOP    = 3'd2;
    localparam logic [STAT_W-1:0] ST_ERROR   = 3'd3;
    localparam logic [STAT_W-1:0] ST_CLOSE   = 3'd4;

    // Bytes left that a donor that is not stopped must exceed before it is halved
    localparam int SPLIT_MIN_ERROR = 1024;
    localparam int SPLIT_MIN_OTHER = 10240;

    // Table write kinds
    typedef enum logic [2:0] {
        WR_NONE,
        WR_PROGRESS,
        WR_STATUS,
        WR_SPLIT,
        WR_CLOSE,
        WR_TAKER,
        WR_DONOR
    } wr_kind_t;

    // Table read address select
    typedef enum logic [1:0] {
        RD_SLOT,
        RD_CNT,
        RD_BEST
    } rd_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     load;
        logic     div_start;
        logic     cnt_clr;
        logic     cnt_inc;
        logic     scan_clr;
        logic     rd_en;
        rd_sel_t  rd_sel;
        wr_kind_t wr_kind;
        logic     ok_set;
        logic     res_load;
    } dss_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            inact;
        logic            ns_ok;
        logic            split_ok;
        logic            div_busy;
        logic            cnt_last;
        logic            worker_done;
        logic            found;
        logic            donor_stopped;
        logic            donor_big;
    } dss_sts_t;

endpackage

// ----- rtl/dss_req_if.sv -----
// Request channel: operation items into the scheduler.
interface dss_req_if import dss_pkg::*;;
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [SLOT_W-1:0]  slot;
    logic [BYTES_W-1:0] amount;
    logic [STAT_W-1:0]  new_state;

    modport source (output valid, output op, output slot, output amount,
                    output new_state, input ready);
    modport sink   (input valid, input op, input slot, input amount,
                    input new_state, output ready);
endinterface

// ----- rtl/dss_rsp_if.sv -----
// Response channel: result items out of the scheduler.
interface dss_rsp_if import dss_pkg::*;;
    logic               valid;
    logic               ready;
    logic               ok;
    logic [BYTES_W-1:0] slot_begin;
    logic [BYTES_W-1:0] slot_size;
    logic [BYTES_W-1:0] slot_got;
    logic [STAT_W-1:0]  slot_status;
    logic [BYTES_W-1:0] bytes_done_total;

    modport source (output valid, output ok, output slot_begin, output slot_size,
                    output slot_got, output slot_status, output bytes_done_total,
                    input ready);
    modport sink   (input valid, input ok, input slot_begin, input slot_size,
                    input slot_got, input slot_status, input bytes_done_total,
                    output ready);
endinterface

// ----- rtl/dss_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
module dss_div #(
    parameter int DW = 48,
    parameter int VW = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic [DW-1:0] quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW-1:0] q_reg;
    logic [VW-1:0] rem_reg;
    logic [VW:0]   trial;
    logic          fits;

    // Shift next dividend bit into the partial remainder
    always_comb
    begin
        trial = {rem_reg, q_reg[DW-1]};
        fits  = trial >= {1'b0, divisor};
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= cnt_reg != CW'(1);
        end
    end

    // Advance quotient and remainder
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DW-2:0], fits};
            rem_reg <= fits ? VW'(trial - {1'b0, divisor}) : VW'(trial);
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;
endmodule

// ----- rtl/dss_dp.sv -----
// Datapath: segment table, configuration, scan and result registers.
module dss_dp import dss_pkg::*; #(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int OFFSET_BITS  = DEF_OFFSET_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CFGI_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic [OP_W-1:0]    in_op,
    input  logic [SLOT_W-1:0]  in_slot,
    input  logic [BYTES_W-1:0] in_amount,
    input  logic [STAT_W-1:0]  in_new_state,
    input  dss_cmd_t           cmd,
    output dss_sts_t           sts,
    output logic               res_ok,
    output logic [BYTES_W-1:0] res_begin,
    output logic [BYTES_W-1:0] res_size,
    output logic [BYTES_W-1:0] res_got,
    output logic [STAT_W-1:0]  res_status,
    output logic [BYTES_W-1:0] res_total
);
    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int OB = OFFSET_BITS;

    // Configuration
    logic [BYTES_W-1:0] task_reg;
    logic [WC_W-1:0]    wc_reg;
    logic [WC_W-1:0]    act;

    // Latched request
    logic [OP_W-1:0]    op_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [BYTES_W-1:0] amount_reg;
    logic [STAT_W-1:0]  ns_reg;
    logic [AW-1:0]      slot_addr;

    // Table storage
    logic [OB-1:0]     mem_start [MAX_SEGMENTS];
    logic [OB-1:0]     mem_size  [MAX_SEGMENTS];
    logic [OB-1:0]     mem_done  [MAX_SEGMENTS];
    logic [STAT_W-1:0] mem_stat  [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] vs_reg, vz_reg, vd_reg, vt_reg;

    // Read port
    logic [AW-1:0]     rd_addr;
    logic [OB-1:0]     rd_start_reg, rd_size_reg, rd_done_reg;
    logic [STAT_W-1:0] rd_stat_reg;

    // Write port
    logic [AW-1:0]     wr_addr;
    logic              we_s, we_z, we_d, we_t;
    logic [OB-1:0]     wd_start, wd_size, wd_done;
    logic [STAT_W-1:0] wd_stat;

    // Sequencing and scan
    logic [AW-1:0]      cnt_reg;
    logic [BYTES_W-1:0] acc_reg;
    logic [BYTES_W-1:0] per;
    logic               div_busy;
    logic               scan_pend_reg;
    logic [AW-1:0]      scan_idx_reg;
    logic [AW-1:0]      best_reg;
    logic [OB-1:0]      left_reg;
    logic               found_reg;
    logic [OB-1:0]      rem;
    logic [OB-1:0]      half;
    logic               cnt_last;

    // Progress sums
    logic [OB:0]   slot_sum, glob_sum;
    logic [OB-1:0] done_sat, glob_sat;
    logic [OB-1:0] glob_reg;
    logic          ok_reg;

    dss_div #(.DW(BYTES_W), .VW(WC_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (task_reg),
        .divisor  (act),
        .busy     (div_busy),
        .quotient (per)
    );

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_reg <= '0;
            wc_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TASK_SIZE:    task_reg <= cfg_data;
                CFG_WORKER_COUNT: wc_reg   <= WC_W'(cfg_data);
                default:          ;
            endcase
        end
    end

    assign act       = (32'(wc_reg) < MAX_SEGMENTS) ? wc_reg : WC_W'(MAX_SEGMENTS);
    assign slot_addr = AW'(slot_reg);

    // Latch the request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= in_op;
            slot_reg   <= in_slot;
            amount_reg <= in_amount;
            ns_reg     <= in_new_state;
        end
    end

    // Saturating progress sums
    always_comb
    begin
        slot_sum = {1'b0, rd_done_reg} + {1'b0, OB'(amount_reg)};
        glob_sum = {1'b0, glob_reg} + {1'b0, OB'(amount_reg)};
        done_sat = slot_sum[OB] ? '1 : slot_sum[OB-1:0];
        glob_sat = glob_sum[OB] ? '1 : glob_sum[OB-1:0];
        rem      = (rd_done_reg < rd_size_reg) ? rd_size_reg - rd_done_reg : '0;
        half     = left_reg >> 1;
        cnt_last = (32'(cnt_reg) + 1) == 32'(act);
    end

    // Select read address
    always_comb
    begin
        case (cmd.rd_sel)
            RD_CNT:  rd_addr = cnt_reg;
            RD_BEST: rd_addr = best_reg;
            default: rd_addr = slot_addr;
        endcase
    end

    // Build the table write
    always_comb
    begin
        wr_addr  = slot_addr;
        we_s     = 1'b0;
        we_z     = 1'b0;
        we_d     = 1'b0;
        we_t     = 1'b0;
        wd_start = '0;
        wd_size  = '0;
        wd_done  = '0;
        wd_stat  = ST_READY;
        case (cmd.wr_kind)
            WR_PROGRESS:
            begin
                we_d    = 1'b1;
                wd_done = done_sat;
            end
            WR_STATUS:
            begin
                we_t    = 1'b1;
                wd_stat = ns_reg;
            end
            WR_SPLIT:
            begin
                wr_addr  = cnt_reg;
                {we_s, we_z, we_d, we_t} = 4'b1111;
                wd_start = OB'(acc_reg);
                wd_size  = cnt_last ? OB'(task_reg - acc_reg) : OB'(per);
            end
            WR_CLOSE:
            begin
                {we_s, we_z, we_d, we_t} = 4'b1111;
                wd_start = OB'(task_reg);
                wd_stat  = ST_CLOSE;
            end
            WR_TAKER:
            begin
                {we_s, we_z, we_d, we_t} = 4'b1111;
                if (rd_stat_reg == ST_STOP)
                begin
                    wd_start = rd_start_reg + rd_done_reg;
                    wd_size  = left_reg;
                end
                else
                begin
                    wd_start = rd_start_reg + rd_size_reg - half;
                    wd_size  = half;
                end
            end
            WR_DONOR:
            begin
                wr_addr = best_reg;
                we_z    = 1'b1;
                if (rd_stat_reg == ST_STOP)
                begin
                    we_t    = 1'b1;
                    wd_size = rd_size_reg - left_reg;
                    wd_stat = ST_CLOSE;
                end
                else
                begin
                    wd_size = rd_size_reg - half;
                end
            end
            default: ;
        endcase
    end

    // Mark written fields valid; unwritten fields read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vs_reg <= '0;
            vz_reg <= '0;
            vd_reg <= '0;
            vt_reg <= '0;
        end
        else
        begin
            if (we_s) vs_reg[wr_addr] <= 1'b1;
            if (we_z) vz_reg[wr_addr] <= 1'b1;
            if (we_d) vd_reg[wr_addr] <= 1'b1;
            if (we_t) vt_reg[wr_addr] <= 1'b1;
        end
    end

    // Write and read the table
    always_ff @(posedge clk)
    begin
        if (we_s) mem_start[wr_addr] <= wd_start;
        if (we_z) mem_size[wr_addr]  <= wd_size;
        if (we_d) mem_done[wr_addr]  <= wd_done;
        if (we_t) mem_stat[wr_addr]  <= wd_stat;
        if (cmd.rd_en)
        begin
            rd_start_reg <= vs_reg[rd_addr] ? mem_start[rd_addr] : '0;
            rd_size_reg  <= vz_reg[rd_addr] ? mem_size[rd_addr]  : '0;
            rd_done_reg  <= vd_reg[rd_addr] ? mem_done[rd_addr]  : '0;
            rd_stat_reg  <= vt_reg[rd_addr] ? mem_stat[rd_addr]  : ST_READY;
        end
    end

    // Advance slot counter, scan pipe and global count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            scan_pend_reg <= 1'b0;
            found_reg     <= 1'b0;
            glob_reg      <= '0;
            ok_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_clr)
                cnt_reg <= '0;
            else if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + 1'b1;
            scan_pend_reg <= cmd.rd_en && (cmd.rd_sel == RD_CNT);
            if (cmd.scan_clr)
                found_reg <= 1'b0;
            else if (scan_pend_reg && scan_idx_reg != slot_addr
                     && rd_stat_reg != ST_CLOSE && rem > left_reg)
                found_reg <= 1'b1;
            if (cmd.wr_kind == WR_PROGRESS)
                glob_reg <= glob_sat;
            if (cmd.load)
                ok_reg <= 1'b0;
            else if (cmd.ok_set)
                ok_reg <= 1'b1;
        end
    end

    // Track the best donor and the running split offset
    always_ff @(posedge clk)
    begin
        scan_idx_reg <= cnt_reg;
        if (cmd.cnt_clr)
            acc_reg <= '0;
        else if (cmd.cnt_inc)
            acc_reg <= acc_reg + per;
        if (cmd.scan_clr)
        begin
            left_reg <= '0;
            best_reg <= '0;
        end
        else if (scan_pend_reg && scan_idx_reg != slot_addr
                 && rd_stat_reg != ST_CLOSE && rem > left_reg)
        begin
            left_reg <= rem;
            best_reg <= scan_idx_reg;
        end
    end

    // Load the result
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_ok    <= ok_reg;
            res_total <= BYTES_W'(glob_reg);
            if (32'(slot_reg) < MAX_SEGMENTS)
            begin
                res_begin  <= BYTES_W'(rd_start_reg);
                res_size   <= BYTES_W'(rd_size_reg);
                res_got    <= BYTES_W'(rd_done_reg);
                res_status <= rd_stat_reg;
            end
            else
            begin
                res_begin  <= '0;
                res_size   <= '0;
                res_got    <= '0;
                res_status <= ST_READY;
            end
        end
    end

    // Report status
    always_comb
    begin
        sts.op            = op_reg;
        sts.inact         = {1'b0, slot_reg} < act;
        sts.ns_ok         = ns_reg <= ST_CLOSE;
        sts.split_ok      = (act != '0) && (task_reg != '0);
        sts.div_busy      = div_busy;
        sts.cnt_last      = cnt_last;
        sts.worker_done   = rd_done_reg >= rd_size_reg;
        sts.found         = found_reg;
        sts.donor_stopped = rd_stat_reg == ST_STOP;
        sts.donor_big     = (rd_stat_reg == ST_ERROR) ? (left_reg > OB'(SPLIT_MIN_ERROR))
                                                      : (left_reg > OB'(SPLIT_MIN_OTHER));
    end
endmodule

// ----- rtl/dss_ctrl.sv -----
// Controller: sequences each operation over the datapath.
module dss_ctrl import dss_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    input  dss_sts_t sts,
    output dss_cmd_t cmd
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PROG_WR,
        S_DIV_WAIT,
        S_SPLIT,
        S_CHK_W,
        S_SCAN,
        S_SCAN_END,
        S_RD_D,
        S_CHK_D,
        S_WR_D,
        S_RD_FIN,
        S_CAP
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    // Decode state into commands
    always_comb
    begin
        cmd            = '0;
        cmd.rd_sel     = RD_SLOT;
        cmd.wr_kind    = WR_NONE;
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RD_FIN;
                unique case (sts.op)
                    OP_SPLIT:
                    begin
                        if (sts.split_ok)
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV_WAIT;
                        end
                    end
                    OP_PROGRESS:
                    begin
                        if (sts.inact)
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = S_PROG_WR;
                        end
                    end
                    OP_STATUS:
                    begin
                        if (sts.inact && sts.ns_ok)
                        begin
                            cmd.wr_kind = WR_STATUS;
                            cmd.ok_set  = 1'b1;
                        end
                    end
                    OP_REASSIGN:
                    begin
                        if (sts.inact)
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = S_CHK_W;
                        end
                    end
                    OP_QUERY:
                        cmd.ok_set = sts.inact;
                    default: ;
                endcase
            end
            S_PROG_WR:
            begin
                cmd.wr_kind = WR_PROGRESS;
                cmd.ok_set  = 1'b1;
                state_next  = S_RD_FIN;
            end
            S_DIV_WAIT:
            begin
                if (!sts.div_busy)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                cmd.wr_kind = WR_SPLIT;
                cmd.cnt_inc = 1'b1;
                if (sts.cnt_last)
                begin
                    cmd.ok_set = 1'b1;
                    state_next = S_RD_FIN;
                end
            end
            S_CHK_W:
            begin
                state_next = S_RD_FIN;
                if (sts.worker_done)
                begin
                    cmd.cnt_clr  = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = RD_CNT;
                cmd.cnt_inc = 1'b1;
                if (sts.cnt_last)
                    state_next = S_SCAN_END;
            end
            S_SCAN_END:
                state_next = S_RD_D;
            S_RD_D:
            begin
                if (sts.found)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_BEST;
                    state_next = S_CHK_D;
                end
                else
                begin
                    cmd.wr_kind = WR_CLOSE;
                    cmd.ok_set  = 1'b1;
                    state_next  = S_RD_FIN;
                end
            end
            S_CHK_D:
            begin
                cmd.ok_set = 1'b1;
                if (sts.donor_stopped || sts.donor_big)
                begin
                    cmd.wr_kind = WR_TAKER;
                    state_next  = S_WR_D;
                end
                else
                begin
                    cmd.wr_kind = WR_CLOSE;
                    state_next  = S_RD_FIN;
                end
            end
            S_WR_D:
            begin
                cmd.wr_kind = WR_DONOR;
                state_next  = S_RD_FIN;
            end
            S_RD_FIN:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_CAP;
            end
            S_CAP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.res_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Hold state and the response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
endmodule

// ----- rtl/download_segment_scheduler.sv -----
// Top level of the download segment scheduler.
//
// Usage: configuration is written on cfg_we/cfg_index/cfg_data (index 0 task
// size, index 1 worker count) while the block is idle. Requests arrive on the
// req channel, one per transfer; each yields exactly one transfer on rsp with
// the addressed segment after the operation and the global byte count.
// Per request: split runs a 48-bit bit-serial divide, then one table write
// per active worker N; a reassign of a finished worker does one table read
// per active worker in the scan.
// The segment table and the sequencer handle one request at a time;
// the next request is taken once the current one has reached the response
// register, even if that response is still waiting.
// Reset clears the table (per-entry valid flags), the global count and the
// configuration. A stalled receiver holds the response; the sequencer waits in
// its final step until the response register frees up.
module download_segment_scheduler import dss_pkg::*; #(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int OFFSET_BITS  = DEF_OFFSET_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFGI_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    dss_req_if.sink           req,
    dss_rsp_if.source         rsp
);
    dss_cmd_t cmd;
    dss_sts_t sts;

    dss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dss_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_op        (req.op),
        .in_slot      (req.slot),
        .in_amount    (req.amount),
        .in_new_state (req.new_state),
        .cmd          (cmd),
        .sts          (sts),
        .res_ok       (rsp.ok),
        .res_begin    (rsp.slot_begin),
        .res_size     (rsp.slot_size),
        .res_got      (rsp.slot_got),
        .res_status   (rsp.slot_status),
        .res_total    (rsp.bytes_done_total)
    );
endmodule
